// ===== rtl/msp_request_frame_receiver_unit_assert.svh =====
// Assertion macros shared by the frame receiver RTL.
`ifndef MSP_REQUEST_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define MSP_REQUEST_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msp frame receiver: assertion failed");

// Implication checked in the following cycle.
`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msp frame receiver: assertion failed");

`else

`define MSP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/msp_rfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msp_rfr_pkg;

   // Bytes per frame buffer; two buffers share one store.
   localparam int BUFFER_DEPTH = 64;
   localparam int STORE_DEPTH  = 2 * BUFFER_DEPTH;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int POS_W        = $clog2(BUFFER_DEPTH + 1);
   // Byte plus overhead, and any position, compared in this width.
   localparam int SUM_W        = (POS_W > 9) ? POS_W : 9;

   localparam int OUTQ_DEPTH   = 3;
   localparam int OUTQ_PTR_W   = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

   localparam int REQ_DATA_W   = 16;
   localparam int REQ_USER_W   = 3;
   localparam int RSP_DATA_W   = 16;

   localparam logic [7:0] HDR_FIRST  = 8'h24;   // '$'
   localparam logic [7:0] HDR_SECOND = 8'h4D;   // 'M'
   localparam logic [7:0] HDR_THIRD  = 8'h3C;   // '<'
   localparam logic [SUM_W-1:0] FRAME_OVERHEAD = SUM_W'(6);
   localparam logic [POS_W-1:0] LEN_POS        = POS_W'(3);

   typedef enum logic [1:0] {
      ACT_RX    = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef struct packed {
      logic frame_done;
      logic done_buffer;
      logic frame_dropped;
      logic ready_first;
      logic ready_second;
      logic is_read;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/msp_request_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                       Beat
// req       in         req_tvalid/tready/tdata/tuser  one action
// rsp       out        rsp_tvalid/tready/tdata        one result per action
//
// One beat accepted per cycle while req_tready is high. The header parser result
// and the frame store write and read are registered; results then wait in a
// three-entry output queue, and req_tready drops only when the parser stage plus
// that queue hold three results.
// Synchronous reset returns to header hunt with both buffers not ready;
// frame store contents are undefined until written.
module msp_request_frame_receiver_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [7:0] rx_byte, [13:8] read_position, [15:14] zero
   input  wire logic [msp_rfr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] action, [2] buffer_select
   input  wire logic [msp_rfr_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] frame_done, [1] done_buffer, [2] frame_dropped, [3] ready_first,
   // [4] ready_second, [12:5] read_data, [15:13] zero
   output logic [msp_rfr_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import msp_rfr_pkg::*;

   logic                  accept;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [7:0]            wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [7:0]            rd_data;
   logic                  res_valid;
   result_type            res;
   logic [7:0]            read_data;
   logic [RSP_DATA_W-1:0] beat;
   logic [OUTQ_CNT_W-1:0] q_count;
   logic [OUTQ_CNT_W:0]   occupancy;

   assign occupancy  = {1'b0, q_count} + (OUTQ_CNT_W + 1)'(res_valid);
   assign req_tready = occupancy < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
   assign accept     = req_tvalid & req_tready;

   msp_rfr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .action        (action_type'(req_tuser[1:0])),
      .rx_byte       (req_tdata[7:0]),
      .buffer_select (req_tuser[2]),
      .read_position (req_tdata[13:8]),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .res_valid     (res_valid),
      .res           (res)
   );

   msp_rfr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // RAM read data lines up with the parser result register.
   assign read_data = res.is_read ? rd_data : 8'h00;
   assign beat = {3'b000, read_data, res.ready_second, res.ready_first,
                  res.frame_dropped, res.done_buffer, res.frame_done};

   msp_rfr_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (beat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .count      (q_count)
   );

endmodule

`default_nettype wire

// ===== rtl/msp_rfr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msp_rfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/msp_rfr_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "msp_request_frame_receiver_unit_assert.svh"

module msp_rfr_parser (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire msp_rfr_pkg::action_type      action,
   input  wire logic [7:0]                   rx_byte,
   input  wire logic                         buffer_select,
   input  wire logic [5:0]                   read_position,
   output logic                              wr_en,
   output logic [msp_rfr_pkg::ADDR_W-1:0]    wr_addr,
   output logic [7:0]                        wr_data,
   output logic                              rd_en,
   output logic [msp_rfr_pkg::ADDR_W-1:0]    rd_addr,
   output logic                              res_valid,
   output msp_rfr_pkg::result_type           res
);
   import msp_rfr_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       len_ff, len_in;
   logic             act_ff, act_in;
   logic             rdy0_ff, rdy0_in;
   logic             rdy1_ff, rdy1_in;
   logic             res_valid_ff;
   result_type       res_ff, res_in;

   logic [ADDR_W-1:0] wr_base;
   logic [ADDR_W-1:0] rd_base;
   logic [SUM_W-1:0]  len_sum;
   logic [SUM_W-1:0]  pos_wide;
   logic              done;
   logic              dropped;
   logic              store;

   assign wr_base = act_ff ? ADDR_W'(BUFFER_DEPTH) : '0;
   assign rd_base = buffer_select ? ADDR_W'(BUFFER_DEPTH) : '0;
   assign wr_addr = wr_base + ADDR_W'(pos_ff);
   assign rd_addr = rd_base + ADDR_W'(read_position);
   assign wr_data = rx_byte;
   assign wr_en   = store;

   always_comb begin
      pos_in   = pos_ff;
      len_in   = len_ff;
      act_in   = act_ff;
      rdy0_in  = rdy0_ff;
      rdy1_in  = rdy1_ff;
      store    = 1'b0;
      rd_en    = 1'b0;
      done     = 1'b0;
      dropped  = 1'b0;
      len_sum  = SUM_W'(rx_byte) + FRAME_OVERHEAD;
      pos_wide = '0;
      res_in   = '0;

      if (accept) begin
         unique case (action)
            ACT_RX: begin
               priority if (pos_ff == '0) begin
                  if (rx_byte == HDR_FIRST) begin
                     store  = 1'b1;
                     pos_in = POS_W'(1);
                  end
               end else if (pos_ff == POS_W'(1)) begin
                  if (rx_byte == HDR_SECOND) begin
                     store  = 1'b1;
                     pos_in = POS_W'(2);
                  end else begin
                     pos_in = '0;
                  end
               end else if (pos_ff == POS_W'(2)) begin
                  if (rx_byte == HDR_THIRD) begin
                     store  = 1'b1;
                     pos_in = LEN_POS;
                  end else begin
                     pos_in = '0;
                  end
               end else if (pos_ff == LEN_POS) begin
                  // Oversized frame: drop it before it can run past the buffer.
                  if (len_sum > SUM_W'(BUFFER_DEPTH)) begin
                     dropped = 1'b1;
                     pos_in  = '0;
                  end else begin
                     len_in = rx_byte;
                     store  = 1'b1;
                     pos_in = pos_ff + POS_W'(1);
                  end
               end else begin
                  store  = 1'b1;
                  pos_in = pos_ff + POS_W'(1);
               end

               pos_wide = SUM_W'(pos_in);
               if (pos_in > LEN_POS &&
                   pos_wide == SUM_W'(len_in) + FRAME_OVERHEAD) begin
                  done   = 1'b1;
                  pos_in = '0;
                  act_in = ~act_ff;
                  if (act_ff) begin
                     rdy1_in = 1'b1;
                  end else begin
                     rdy0_in = 1'b1;
                  end
               end
            end
            ACT_READ: begin
               rd_en = SUM_W'(read_position) < SUM_W'(BUFFER_DEPTH);
            end
            ACT_CLEAR: begin
               if (buffer_select) begin
                  rdy1_in = 1'b0;
               end else begin
                  rdy0_in = 1'b0;
               end
            end
            default: begin
            end
         endcase

         res_in.frame_done    = done;
         res_in.done_buffer   = done & act_ff;
         res_in.frame_dropped = dropped;
         res_in.ready_first   = rdy0_in;
         res_in.ready_second  = rdy1_in;
         res_in.is_read       = rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         len_ff       <= '0;
         act_ff       <= 1'b0;
         rdy0_ff      <= 1'b0;
         rdy1_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         act_ff       <= act_in;
         rdy0_ff      <= rdy0_in;
         rdy1_ff      <= rdy1_in;
         res_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   `MSP_ASSERT_IMPLY(a_pos_in_range, clock, reset, 1'b1,
      SUM_W'(pos_ff) < SUM_W'(BUFFER_DEPTH))
   `MSP_ASSERT_IMPLY(a_done_not_dropped, clock, reset, res_valid_ff,
      !(res_ff.frame_done && res_ff.frame_dropped))
   `MSP_ASSERT_IMPLY(a_done_rehunts, clock, reset,
      res_valid_ff && (res_ff.frame_done || res_ff.frame_dropped), pos_ff == '0)

endmodule

`default_nettype wire

// ===== rtl/msp_rfr_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "msp_request_frame_receiver_unit_assert.svh"

module msp_rfr_outq (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire logic [msp_rfr_pkg::RSP_DATA_W-1:0] push_data,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [msp_rfr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [msp_rfr_pkg::OUTQ_CNT_W-1:0]     count
);
   import msp_rfr_pkg::*;

   logic [RSP_DATA_W-1:0] slot_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  pop;

   assign pop = rsp_tvalid & rsp_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                     : wr_ptr_ff + OUTQ_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                     : rd_ptr_ff + OUTQ_PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + OUTQ_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - OUTQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = slot_ff[rd_ptr_ff];
   assign count      = cnt_ff;

   `MSP_ASSERT_IMPLY(a_no_overflow, clock, reset, push,
      cnt_ff != OUTQ_CNT_W'(OUTQ_DEPTH) || pop)
   `MSP_ASSERT_NEXT(a_count_holds, clock, reset, !push && !pop, $stable(cnt_ff))

endmodule

`default_nettype wire
